// ===== src/regex_star_dot_matcher_core_macros.svh =====
// Assertion macros for the matcher core RTL.
`ifndef REGEX_STAR_DOT_MATCHER_CORE_MACROS_SVH
`define REGEX_STAR_DOT_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSDM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rsdm_pkg.sv =====
// Types, codes and helpers for the star/dot pattern matcher.
package rsdm_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_TEXT    = 2'd1,
      FUNC_RESTART = 2'd2
   } func_type;

   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_ANY  = 8'h2E;

   function automatic logic elem_hits(input logic [7:0] pc, input logic [7:0] c);
      return (pc == CH_ANY) || (pc == c);
   endfunction

endpackage

// ===== src/rsdm_row_step.sv =====
// Next match row: empty-text row of a pattern, or the row advanced by one text byte.
module rsdm_row_step
   import rsdm_pkg::*;
#(
   parameter int MAX_PATTERN = 32,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic [MAX_PATTERN-1:0][7:0] pat,
   input  logic [LEN_W-1:0]            len,
   input  logic [MAX_PATTERN:0]        row,
   input  logic [7:0]                  ch,
   input  logic                        text_mode,
   output logic [MAX_PATTERN:0]        row_out
);

   always_comb begin
      logic [MAX_PATTERN:0] nxt;
      logic                 more;
      nxt  = '0;
      more = 1'b0;
      nxt[0] = ~text_mode;
      // first element: a leading star never matches
      if ((len != '0) && (pat[0] != CH_STAR)) begin
         nxt[1] = text_mode & elem_hits(pat[0], ch) & row[0];
      end
      // star groups ripple from two positions back
      for (int j = 1; j < MAX_PATTERN; j++) begin
         if (LEN_W'(j) < len) begin
            if (pat[j] == CH_STAR) begin
               more       = text_mode & elem_hits(pat[j-1], ch) & row[j+1];
               nxt[j+1]   = nxt[j-1] | more;
            end else begin
               nxt[j+1]   = text_mode & elem_hits(pat[j], ch) & row[j];
            end
         end
      end
      row_out = nxt;
   end

endmodule

// ===== src/regex_star_dot_matcher_core.sv =====
// Top level of the streaming star/dot pattern matcher.
//
// req_ channel carries one beat per command: req_func selects pattern load,
// text byte or restart; req_char_in is the byte; req_pattern_end marks the
// last pattern byte. A beat is taken when req_valid is high and req_stall low.
// rsp_ channel returns exactly one beat per request, in order: rsp_matched
// says the text since the last restart matches the whole stored pattern,
// rsp_pattern_overflow says pattern bytes beyond MAX_PATTERN were dropped.
// A request beat passes through the input register, then one pass of row logic
// into the response register, which drives the response beat. Throughput is one
// beat per cycle while no pending response is held by rsp_stall; the row update
// is a single pass over all pattern positions with an OR ripple along star groups.
// When rsp_stall is high with a response pending, the held request stays in
// the input register and req_stall rises; nothing is lost or repeated.
// Synchronous reset clears both registers' valid flags, the pattern length,
// the complete and overflow flags, and sets the match row to bit zero only.
// The pattern bytes themselves are not reset.
module regex_star_dot_matcher_core
   import rsdm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_in,
   input  logic       req_pattern_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);

`include "regex_star_dot_matcher_core_macros.svh"

   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // input register
   logic       in_valid_ff;
   logic [1:0] func_ff;
   logic [7:0] char_ff;
   logic       end_ff;

   // matcher state
   logic [MAX_PATTERN-1:0][7:0] store_ff, store_in;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic                        complete_ff, complete_in;
   logic                        ovf_ff, ovf_in;
   logic [MAX_PATTERN:0]        row_ff, row_in;

   // response register
   logic rsp_valid_ff;
   logic matched_ff, matched_in;
   logic rsp_ovf_ff;

   logic                 advance;
   logic                 text_mode;
   logic                 row_load;
   logic [MAX_PATTERN:0] row_calc;
   logic [LEN_W-1:0]     base_len;

   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         func_ff <= req_func;
         char_ff <= req_char_in;
         end_ff  <= req_pattern_end;
      end
   end

   always_comb begin
      store_in    = store_ff;
      len_in      = len_ff;
      complete_in = complete_ff;
      ovf_in      = ovf_ff;
      text_mode   = 1'b0;
      row_load    = 1'b0;
      base_len    = complete_ff ? '0 : len_ff;
      case (func_type'(func_ff))
         FUNC_LOAD: begin
            if (complete_ff) begin
               complete_in = 1'b0;
               ovf_in      = 1'b0;
            end
            len_in = base_len;
            if (base_len < LEN_W'(MAX_PATTERN)) begin
               store_in[base_len[ADDR_W-1:0]] = char_ff;
               len_in = base_len + LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            if (end_ff) begin
               complete_in = 1'b1;
               row_load    = 1'b1;
            end
         end
         FUNC_TEXT: begin
            if (complete_ff) begin
               text_mode = 1'b1;
               row_load  = 1'b1;
            end
         end
         FUNC_RESTART: begin
            row_load = 1'b1;
         end
         default: begin
         end
      endcase
      row_in     = row_load ? row_calc : row_ff;
      matched_in = complete_in & row_in[len_in];
   end

   rsdm_row_step #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_row_step (
      .pat       (store_in),
      .len       (len_in),
      .row       (row_ff),
      .ch        (char_ff),
      .text_mode (text_mode),
      .row_out   (row_calc)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         store_ff <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         complete_ff <= 1'b0;
         ovf_ff      <= 1'b0;
         row_ff      <= {{MAX_PATTERN{1'b0}}, 1'b1};
      end else if (advance) begin
         len_ff      <= len_in;
         complete_ff <= complete_in;
         ovf_ff      <= ovf_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         matched_ff <= matched_in;
         rsp_ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   `RSDM_ASSERT_NOW(a_match_from_state, clock, reset, rsp_valid_ff && matched_ff, complete_ff && row_ff[len_ff], "pending match beat disagrees with match state")
   `RSDM_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_W'(MAX_PATTERN), "pattern length beyond capacity")
   `RSDM_ASSERT_NOW(a_ovf_full, clock, reset, ovf_ff, len_ff == LEN_W'(MAX_PATTERN), "overflow flagged with room left")
   `RSDM_ASSERT_NEXT(a_ovf_beat, clock, reset, advance, rsp_valid_ff && (rsp_ovf_ff == ovf_ff), "overflow beat differs from state")

endmodule

// ===== bench/regex_star_dot_matcher_core_tb.sv =====
// Self-checking bench: pattern/text streams vs. a row-of-bits match predictor.
module regex_star_dot_matcher_core_tb
   import rsdm_pkg::*;
();

   localparam int MAX_PAT = 32;
   localparam int BEAT_TARGET = 1580;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic matched;
      logic overflow;
   } match_status_type;

   class match_scoreboard;
      logic [7:0] pat_mem [MAX_PAT];
      int unsigned pat_len;
      bit pat_done;
      bit ovf;
      bit [MAX_PAT:0] row;
      match_status_type status_q [$];
      int errors;

      function new();
         pat_len = 0;
         pat_done = 1'b0;
         ovf = 1'b0;
         row = '0;
         row[0] = 1'b1;
         errors = 0;
      endfunction

      function void restart_row();
         row = '0;
         row[0] = 1'b1;
         for (int j = 1; j < pat_len; j++)
            if (pat_mem[j] == CH_STAR)
               row[j + 1] = row[j - 1];
      endfunction

      function void advance_row(logic [7:0] c);
         bit [MAX_PAT:0] nxt;
         logic [7:0] pc;
         nxt = '0;
         for (int j = 0; j < pat_len; j++) begin
            pc = pat_mem[j];
            if (pc == CH_STAR) begin
               if (j >= 1)
                  nxt[j + 1] = nxt[j - 1] |
                     ((pat_mem[j - 1] == CH_ANY || pat_mem[j - 1] == c) & row[j + 1]);
            end else if (pc == CH_ANY || pc == c) begin
               nxt[j + 1] = row[j];
            end
         end
         row = nxt;
      endfunction

      function void note_request(logic [1:0] f, logic [7:0] c, logic pe);
         match_status_type s;
         case (f)
            FUNC_LOAD: begin
               if (pat_done) begin
                  pat_len = 0;
                  pat_done = 1'b0;
                  ovf = 1'b0;
               end
               if (pat_len < MAX_PAT) begin
                  pat_mem[pat_len] = c;
                  pat_len++;
               end else begin
                  ovf = 1'b1;
               end
               if (pe) begin
                  pat_done = 1'b1;
                  restart_row();
               end
            end
            FUNC_TEXT: if (pat_done) advance_row(c);
            FUNC_RESTART: restart_row();
            default: ;
         endcase
         s.matched = pat_done ? row[pat_len] : 1'b0;
         s.overflow = ovf;
         status_q.push_back(s);
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic m, logic o);
         match_status_type s;
         if (status_q.size() == 0) begin
            report("response beat with no request outstanding");
         end else begin
            s = status_q.pop_front();
            if (m !== s.matched)
               report($sformatf("matched got %b want %b", m, s.matched));
            if (o !== s.overflow)
               report($sformatf("pattern_overflow got %b want %b", o, s.overflow));
         end
      endtask

      function bit waiting();
         return status_q.size() != 0;
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_LOAD;
   logic [7:0] req_char_in = 8'h00;
   logic       req_pattern_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   match_scoreboard sb;
   int beats_sent = 0;
   bit calm = 1'b0;
   logic [7:0] pat_buf [64];
   int pat_buf_len = 0;

   regex_star_dot_matcher_core #(.MAX_PATTERN(MAX_PAT)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_char_in          (req_char_in),
      .req_pattern_end      (req_pattern_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] pick_text_char();
      logic [7:0] c;
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
      else c = 8'h61 + 8'($urandom_range(2));
      return c;
   endfunction

   function automatic logic [7:0] pick_pat_char();
      logic [7:0] c;
      case ($urandom_range(9))
         0, 1: c = CH_ANY;
         2, 3: c = CH_STAR;
         9: c = 8'($urandom_range(255));
         default: c = 8'h61 + 8'($urandom_range(2));
      endcase
      return c;
   endfunction

   task automatic send_beat(input logic [1:0] f, input logic [7:0] c, input logic pe);
      int gap;
      gap = calm ? 0 : pick_delay();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_char_in <= 8'($urandom_range(255));
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_char_in <= c;
      req_pattern_end <= pe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(f, c, pe);
      beats_sent++;
   endtask

   task automatic load_random_pattern(input int len, input bit finish);
      for (int i = 0; i < len; i++) begin
         pat_buf[i] = pick_pat_char();
         send_beat(FUNC_LOAD, pat_buf[i], finish && (i == len - 1));
      end
      pat_buf_len = (len > MAX_PAT) ? MAX_PAT : len;
   endtask

   // emit text that tends to satisfy the buffered pattern, with some corruption
   task automatic walk_text();
      logic [7:0] c;
      logic [7:0] t;
      int reps;
      for (int j = 0; j < pat_buf_len; j++) begin
         c = pat_buf[j];
         if (c != CH_STAR) begin
            reps = (j + 1 < pat_buf_len && pat_buf[j + 1] == CH_STAR) ?
                   $urandom_range(3) : 1;
            repeat (reps) begin
               t = (c == CH_ANY || $urandom_range(11) == 0) ? pick_text_char() : c;
               send_beat(FUNC_TEXT, t, 1'($urandom_range(1)));
            end
         end
      end
   endtask

   task automatic noise_beat();
      logic [1:0] f;
      logic [7:0] c;
      logic pe;
      f = 2'($urandom_range(3));
      c = 8'($urandom_range(255));
      pe = 1'($urandom_range(1));
      send_beat(f, c, pe);
   endtask

   initial begin
      int r;
      int len;
      int passes;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      calm = 1'b1;
      send_beat(FUNC_TEXT, 8'h61, 1'b0);
      send_beat(FUNC_RESTART, 8'hFF, 1'b1);
      send_beat(FUNC_UNUSED, 8'h00, 1'b0);
      send_beat(FUNC_LOAD, CH_STAR, 1'b1);
      send_beat(FUNC_TEXT, CH_STAR, 1'b0);
      send_beat(FUNC_LOAD, 8'h61, 1'b0);
      send_beat(FUNC_LOAD, CH_STAR, 1'b0);
      send_beat(FUNC_LOAD, CH_STAR, 1'b1);
      send_beat(FUNC_TEXT, 8'h61, 1'b0);
      send_beat(FUNC_TEXT, CH_STAR, 1'b0);
      send_beat(FUNC_TEXT, 8'h62, 1'b0);
      send_beat(FUNC_RESTART, 8'h00, 1'b0);
      send_beat(FUNC_LOAD, 8'h00, 1'b0);
      send_beat(FUNC_LOAD, CH_ANY, 1'b0);
      send_beat(FUNC_LOAD, 8'hFF, 1'b1);
      send_beat(FUNC_TEXT, 8'h00, 1'b0);
      send_beat(FUNC_TEXT, 8'h7F, 1'b0);
      send_beat(FUNC_TEXT, 8'hFF, 1'b0);
      send_beat(FUNC_UNUSED, 8'hFF, 1'b1);
      send_beat(FUNC_RESTART, 8'h00, 1'b0);
      send_beat(FUNC_TEXT, 8'hFF, 1'b0);

      while (beats_sent < BEAT_TARGET) begin
         calm = ($urandom_range(4) == 0);
         r = $urandom_range(99);
         if (r < 8) begin
            repeat ($urandom_range(1, 4)) noise_beat();
         end else begin
            len = (r < 14) ? $urandom_range(29, 40) : $urandom_range(1, 8);
            load_random_pattern(len, r < 96);
            passes = $urandom_range(1, 4);
            for (int k = 0; k < passes; k++) begin
               if (k > 0 || $urandom_range(3) == 0)
                  send_beat(FUNC_RESTART, pick_text_char(), 1'($urandom_range(1)));
               walk_text();
               if ($urandom_range(2) == 0)
                  repeat ($urandom_range(1, 3))
                     send_beat(FUNC_TEXT, pick_text_char(), 1'b0);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.waiting()) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      forever begin
         if ($urandom_range(5) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            len_stall: begin
               int n;
               n = pick_delay();
               if (n > 0) begin
                  rsp_stall <= 1'b1;
                  repeat (n) @(posedge clock);
               end
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_matched, rsp_pattern_overflow);

endmodule
